>>> hw/rtl/srtf_pkg.sv
package srtf_pkg;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  remaining;
    logic [15:0] arrival;
    logic [7:0]  burst;
  } entry_t;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

endpackage

>>> hw/rtl/srtf_ram.sv
module srtf_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/srtf_scheduler_unit.sv
// Shortest-remaining-time-first scheduler over an ordered task list.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; opcode 0 appends a task of burst_len, opcode 1 is one tick.
// Result channel: done is high for exactly one cycle with every result
// port valid; the receiver cannot stall it. busy falls in that same cycle.
// Steps per item, with n tasks held after the item:
//   full arrival or idle tick: answered straight from IDLE
//   arrival: store, scan of n entries, shift of up to n-1
//   tick that does not finish its task: read and write back of the head
//   tick that finishes its task: removal shift, then the scan and shift
//   of the reselection; only the read of the head when no task is left
// The list lives in one RAM with one write and one registered read port;
// the scan and the shifts move one entry per cycle through it.
// Reset clears the task count, time, id counter and last run id; the RAM
// needs no clearing since only entries below the count are read.
module srtf_scheduler_unit
  import srtf_pkg::*;
#(
  parameter int MAX_TASKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [7:0]  burst_len,
  output logic        done,
  output logic        accepted,
  output logic        full_error,
  output logic [7:0]  assigned_id,
  output logic        ran,
  output logic [7:0]  running_id,
  output logic        switched,
  output logic        finished,
  output logic [15:0] turnaround,
  output logic [15:0] waiting,
  output logic [5:0]  task_count
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TASKS);

  typedef enum logic [2:0] {
    IDLE,
    TICK_RD,
    REMOVE,
    SCAN,
    SHIFT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [15:0]   cur_time;
  logic [7:0]    next_id;
  logic [7:0]    last_run_id;
  logic [CW-1:0] ptr;
  logic          pv;
  logic [AW-1:0] pidx;
  logic [AW-1:0] best;
  entry_t        best_q;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic [CW-1:0] ptr_m1;
  logic          take;
  logic [15:0]   ta;

  assign busy   = (state != IDLE);
  assign take   = start && !busy;
  assign ptr_m1 = ptr - 1'b1;
  assign ta     = cur_time - rdata.arrival;

  srtf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_TASKS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = best_q;
    raddr = '0;
    case (state)
      IDLE: begin
        if (take && opcode == OP_ARRIVE && count != MAX_COUNT) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = '{id: next_id, remaining: burst_len, arrival: cur_time,
                    burst: burst_len};
        end
      end
      TICK_RD: begin
        if (rdata.remaining > 8'd1) begin
          we              = 1'b1;
          wdata           = rdata;
          wdata.remaining = rdata.remaining - 8'd1;
        end
      end
      REMOVE: begin
        raddr = ptr[AW-1:0];
        we    = pv;
        waddr = pidx;
        wdata = rdata;
      end
      SCAN: begin
        raddr = ptr[AW-1:0];
      end
      SHIFT: begin
        raddr = ptr_m1[AW-1:0];
        if (pv) begin
          we    = 1'b1;
          waddr = pidx;
          wdata = rdata;
        end else if (ptr == '0) begin
          we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      count       <= '0;
      cur_time    <= '0;
      next_id     <= 8'd1;
      last_run_id <= '0;
      done        <= 1'b0;
      pv          <= 1'b0;
      ptr         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (take) begin
            accepted    <= 1'b0;
            full_error  <= 1'b0;
            assigned_id <= '0;
            ran         <= 1'b0;
            running_id  <= '0;
            switched    <= 1'b0;
            finished    <= 1'b0;
            turnaround  <= '0;
            waiting     <= '0;
            task_count  <= 6'(count);
            if (opcode == OP_ARRIVE) begin
              if (count == MAX_COUNT) begin
                full_error <= 1'b1;
                done       <= 1'b1;
              end else begin
                accepted    <= 1'b1;
                assigned_id <= next_id;
                next_id     <= (next_id == 8'd255) ? 8'd1 : next_id + 8'd1;
                count       <= count + 1'b1;
                ptr         <= '0;
                pv          <= 1'b0;
                state       <= SCAN;
              end
            end else begin
              cur_time <= cur_time + 16'd1;
              if (count == '0) begin
                done <= 1'b1;
              end else begin
                state <= TICK_RD;
              end
            end
          end
        end
        TICK_RD: begin
          ran         <= 1'b1;
          running_id  <= rdata.id;
          switched    <= (rdata.id != last_run_id);
          last_run_id <= rdata.id;
          if (rdata.remaining <= 8'd1) begin
            finished   <= 1'b1;
            turnaround <= ta;
            waiting    <= ta - {8'd0, rdata.burst};
            if (count > CW'(1)) begin
              ptr   <= CW'(1);
              pv    <= 1'b0;
              state <= REMOVE;
            end else begin
              count      <= '0;
              task_count <= '0;
              done       <= 1'b1;
              state      <= IDLE;
            end
          end else begin
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        REMOVE: begin
          pv   <= (ptr < count);
          pidx <= ptr_m1[AW-1:0];
          if (ptr < count) begin
            ptr <= ptr + 1'b1;
          end else if (!pv) begin
            count <= count - 1'b1;
            ptr   <= '0;
            state <= SCAN;
          end
        end
        SCAN: begin
          pv   <= (ptr < count);
          pidx <= ptr[AW-1:0];
          if (ptr < count) begin
            ptr <= ptr + 1'b1;
          end
          if (pv && (pidx == '0 || rdata.remaining <= best_q.remaining)) begin
            best   <= pidx;
            best_q <= rdata;
          end
          if (ptr == count && !pv) begin
            ptr   <= CW'(best);
            state <= SHIFT;
          end
        end
        SHIFT: begin
          pv   <= (ptr != '0);
          pidx <= ptr[AW-1:0];
          if (ptr != '0) begin
            ptr <= ptr_m1;
          end else if (!pv) begin
            task_count <= 6'(count);
            done       <= 1'b1;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("task count beyond capacity");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    done |-> task_count == 6'(count))
    else $error("reported task count differs from held count");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    take && opcode == OP_TICK |=> cur_time == $past(cur_time) + 16'd1)
    else $error("tick did not advance time");

  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(accepted && full_error) && !(ran && (accepted || full_error)))
    else $error("result mixes arrival and tick fields");

endmodule
